[rtl/core/marching_squares_cell_segments_top_assert.svh]
// ----------------------------------------------------------------------------
// Marching squares cell segments - assertion macros
// Shared concurrent assertion forms, clocked on aclk, off while in reset.
// ----------------------------------------------------------------------------
`ifndef MARCHING_SQUARES_CELL_SEGMENTS_TOP_ASSERT_SVH
`define MARCHING_SQUARES_CELL_SEGMENTS_TOP_ASSERT_SVH

// same-cycle implication
`define MSQ_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MSQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/msq_pkg.sv]
// ----------------------------------------------------------------------------
// msq_pkg
// Widths, types and the segment plan shared by the marching squares blocks.
// ----------------------------------------------------------------------------
package msq_pkg;

    localparam int COORD_W      = 12;
    localparam int SIZE_W       = 8;
    localparam int VALUE_W      = 32;
    localparam int OUT_W        = COORD_W + 1;
    localparam int Q_W          = SIZE_W + 1;
    localparam int DEN_W        = VALUE_W + 2;
    localparam int NUM_W        = VALUE_W + SIZE_W + 2;
    localparam int DIV_STAGES   = SIZE_W + 1;
    localparam int FRONT_STAGES = 2;
    localparam int PIPE_STAGES  = FRONT_STAGES + DIV_STAGES;
    localparam int N_SIDES      = 4;

    // bit positions of the corners in the case index
    localparam int BIT_TL = 0;
    localparam int BIT_TR = 1;
    localparam int BIT_BL = 2;
    localparam int BIT_BR = 3;

    localparam logic [3:0] CASE_NONE     = 4'b0000;
    localparam logic [3:0] CASE_FULL     = 4'b1111;
    localparam logic [3:0] CASE_SADDLE_A = 4'b0110;
    localparam logic [3:0] CASE_SADDLE_B = 4'b1001;

    typedef enum logic [1:0] {
        SIDE_TOP    = 2'd0,
        SIDE_LEFT   = 2'd1,
        SIDE_RIGHT  = 2'd2,
        SIDE_BOTTOM = 2'd3
    } side_t;

    typedef struct packed {
        logic        [COORD_W-1:0] cell_x;
        logic        [COORD_W-1:0] cell_y;
        logic        [SIZE_W-1:0]  cell_size;
        logic signed [VALUE_W-1:0] corner_top_left;
        logic signed [VALUE_W-1:0] corner_top_right;
        logic signed [VALUE_W-1:0] corner_bottom_left;
        logic signed [VALUE_W-1:0] corner_bottom_right;
    } msq_in_t;

    typedef struct packed {
        logic [OUT_W-1:0] start_x;
        logic [OUT_W-1:0] start_y;
        logic [OUT_W-1:0] end_x;
        logic [OUT_W-1:0] end_y;
        logic             last_segment;
    } msq_out_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [SIZE_W-1:0]  s;
        logic [3:0]         idx;
    } cell_info_t;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic [Q_W-1:0]   q;
        logic             zero;
    } lane_t;

    typedef struct packed {
        logic [1:0] count;
        side_t      start0;
        side_t      end0;
        side_t      start1;
        side_t      end1;
    } plan_t;

    function automatic plan_t seg_plan(input logic [3:0] idx);
        plan_t p;
        logic  cross_top;
        logic  cross_left;
        logic  cross_right;
        logic  cross_bottom;
        cross_top    = idx[BIT_TL] ^ idx[BIT_TR];
        cross_left   = idx[BIT_TL] ^ idx[BIT_BL];
        cross_right  = idx[BIT_TR] ^ idx[BIT_BR];
        cross_bottom = idx[BIT_BL] ^ idx[BIT_BR];
        p.count  = 2'd1;
        p.start0 = SIDE_TOP;
        p.end0   = SIDE_LEFT;
        p.start1 = SIDE_BOTTOM;
        p.end1   = SIDE_LEFT;
        if (idx == CASE_NONE || idx == CASE_FULL) begin
            p.count = 2'd0;
        end else if (idx == CASE_SADDLE_A || idx == CASE_SADDLE_B) begin
            p.count  = 2'd2;
            p.start0 = SIDE_TOP;
            p.end0   = idx[BIT_TL] ? SIDE_LEFT : SIDE_RIGHT;
            p.start1 = SIDE_BOTTOM;
            p.end1   = idx[BIT_TL] ? SIDE_RIGHT : SIDE_LEFT;
        end else if (cross_top) begin
            p.start0 = SIDE_TOP;
            p.end0   = cross_left ? SIDE_LEFT : (cross_right ? SIDE_RIGHT : SIDE_BOTTOM);
        end else if (cross_bottom) begin
            p.start0 = SIDE_BOTTOM;
            p.end0   = cross_left ? SIDE_LEFT : SIDE_RIGHT;
        end else begin
            p.start0 = SIDE_LEFT;
            p.end0   = SIDE_RIGHT;
        end
        return p;
    endfunction

endpackage

[rtl/core/msq_pipe_ctrl.sv]
// ----------------------------------------------------------------------------
// msq_pipe_ctrl
// Valid bits and cell sideband for every pipeline stage; stage load enables.
// ----------------------------------------------------------------------------
`include "marching_squares_cell_segments_top_assert.svh"

module msq_pipe_ctrl
    import msq_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  cell_info_t             in_info,
    output logic [PIPE_STAGES-1:0] load,
    output logic                   out_valid,
    output cell_info_t             out_info,
    input  logic                   out_ready
);

    logic [PIPE_STAGES-1:0] valid_reg;
    logic [PIPE_STAGES-1:0] valid_next;
    logic [PIPE_STAGES:0]   rdy;
    cell_info_t             info_reg [PIPE_STAGES];

    always_comb begin
        rdy[PIPE_STAGES] = out_ready;
        for (int i = PIPE_STAGES - 1; i >= 0; i--) begin
            rdy[i] = !valid_reg[i] || rdy[i+1];
        end
        valid_next[0] = rdy[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < PIPE_STAGES; i++) begin
            valid_next[i] = rdy[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load[0]) begin
            info_reg[0] <= in_info;
        end
        for (int i = 1; i < PIPE_STAGES; i++) begin
            if (load[i]) begin
                info_reg[i] <= info_reg[i-1];
            end
        end
    end

    assign load      = rdy[PIPE_STAGES-1:0];
    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[PIPE_STAGES-1];
    assign out_info  = info_reg[PIPE_STAGES-1];

    `MSQ_ASSERT_NEXT(a_tail_holds, out_valid && !out_ready, out_valid && $stable(out_info), "pipeline tail item lost while stalled")
    `MSQ_ASSERT_IMPL(a_head_ready, !valid_reg[0], in_ready, "empty first stage refused an item")

endmodule

[rtl/core/msq_front.sv]
// ----------------------------------------------------------------------------
// msq_front
// Corner magnitudes, then per-edge rounding numerator and doubled denominator.
// ----------------------------------------------------------------------------
module msq_front
    import msq_pkg::*;
(
    input  logic                      aclk,
    input  logic                      load0,
    input  logic                      load1,
    input  msq_in_t                   in_data,
    output lane_t [N_SIDES-1:0]       lanes
);

    localparam int CORNER_TL = 0;
    localparam int CORNER_TR = 1;
    localparam int CORNER_BL = 2;
    localparam int CORNER_BR = 3;
    localparam int N_CORNERS = 4;

    logic [VALUE_W-1:0] corner   [N_CORNERS];
    logic [VALUE_W-1:0] mag_reg  [N_CORNERS];
    logic [SIZE_W-1:0]  size_reg;
    lane_t              lane_reg [N_SIDES];
    lane_t              lane_next[N_SIDES];
    logic [1:0]         pair_a   [N_SIDES];
    logic [1:0]         pair_b   [N_SIDES];

    assign corner[CORNER_TL] = in_data.corner_top_left;
    assign corner[CORNER_TR] = in_data.corner_top_right;
    assign corner[CORNER_BL] = in_data.corner_bottom_left;
    assign corner[CORNER_BR] = in_data.corner_bottom_right;

    // corner pair of each edge, offset measured from the first one
    assign pair_a[SIDE_TOP]    = 2'(CORNER_TL);
    assign pair_b[SIDE_TOP]    = 2'(CORNER_TR);
    assign pair_a[SIDE_LEFT]   = 2'(CORNER_TL);
    assign pair_b[SIDE_LEFT]   = 2'(CORNER_BL);
    assign pair_a[SIDE_RIGHT]  = 2'(CORNER_TR);
    assign pair_b[SIDE_RIGHT]  = 2'(CORNER_BR);
    assign pair_a[SIDE_BOTTOM] = 2'(CORNER_BL);
    assign pair_b[SIDE_BOTTOM] = 2'(CORNER_BR);

    always_ff @(posedge aclk) begin
        if (load0) begin
            for (int c = 0; c < N_CORNERS; c++) begin
                mag_reg[c] <= corner[c][VALUE_W-1] ? VALUE_W'(~corner[c] + 1'b1) : corner[c];
            end
            size_reg <= in_data.cell_size;
        end
    end

    always_comb begin
        for (int k = 0; k < N_SIDES; k++) begin
            logic [VALUE_W:0]          sum;
            logic [VALUE_W+SIZE_W-1:0] prod;
            sum  = {1'b0, mag_reg[pair_a[k]]} + {1'b0, mag_reg[pair_b[k]]};
            prod = mag_reg[pair_a[k]] * size_reg;
            lane_next[k].num  = NUM_W'({prod, 1'b0}) + NUM_W'(sum);
            lane_next[k].den  = {sum, 1'b0};
            lane_next[k].q    = '0;
            lane_next[k].zero = (sum == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (load1) begin
            for (int k = 0; k < N_SIDES; k++) begin
                lane_reg[k] <= lane_next[k];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < N_SIDES; k++) begin
            lanes[k] = lane_reg[k];
        end
    end

endmodule

[rtl/core/msq_div_lane.sv]
// ----------------------------------------------------------------------------
// msq_div_lane
// Restoring divider, one quotient bit per stage, MSB first.
// ----------------------------------------------------------------------------
module msq_div_lane
    import msq_pkg::*;
(
    input  logic                  aclk,
    input  logic [DIV_STAGES-1:0] load,
    input  lane_t                 in_lane,
    output logic [Q_W-1:0]        q
);

    lane_t stage_reg [DIV_STAGES];

    for (genvar i = 0; i < DIV_STAGES; i++) begin : g_step
        localparam int QBIT = SIZE_W - i;
        lane_t            cur;
        lane_t            nxt;
        logic [NUM_W-1:0] trial;

        if (i == 0) begin : g_first
            assign cur = in_lane;
        end else begin : g_rest
            assign cur = stage_reg[i-1];
        end

        assign trial = NUM_W'(cur.den) << QBIT;

        always_comb begin
            nxt = cur;
            if (cur.num >= trial) begin
                nxt.num     = cur.num - trial;
                nxt.q[QBIT] = 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (load[i]) begin
                stage_reg[i] <= nxt;
            end
        end
    end

    // zero magnitude sum on an edge gives offset 0
    assign q = stage_reg[DIV_STAGES-1].zero ? '0 : stage_reg[DIV_STAGES-1].q;

endmodule

[rtl/core/msq_emit.sv]
// ----------------------------------------------------------------------------
// msq_emit
// Builds edge points of a finished cell and hands out its one or two segments.
// ----------------------------------------------------------------------------
`include "marching_squares_cell_segments_top_assert.svh"

module msq_emit
    import msq_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  cell_info_t                    in_info,
    input  logic [N_SIDES-1:0][Q_W-1:0]   q,
    output logic                          m_valid,
    output msq_out_t                      m_data,
    input  logic                          m_ready
);

    logic                            valid_reg;
    logic                            valid_next;
    logic                            second_reg;
    logic                            second_next;
    plan_t                           plan_reg;
    plan_t                           plan_in;
    logic [N_SIDES-1:0][OUT_W-1:0]   px_reg;
    logic [N_SIDES-1:0][OUT_W-1:0]   py_reg;
    logic                            take;
    logic                            last;
    logic                            free;
    logic                            load;
    side_t                           s_side;
    side_t                           e_side;

    assign plan_in  = seg_plan(in_info.idx);
    assign take     = valid_reg && m_ready;
    assign last     = second_reg || (plan_reg.count == 2'd1);
    assign free     = !valid_reg || (take && last);
    assign in_ready = free || (plan_in.count == 2'd0);
    assign load     = in_valid && free && (plan_in.count != 2'd0);

    always_comb begin
        valid_next  = valid_reg;
        second_next = second_reg;
        if (take && last) begin
            valid_next  = 1'b0;
            second_next = 1'b0;
        end else if (take) begin
            second_next = 1'b1;
        end
        if (load) begin
            valid_next  = 1'b1;
            second_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end else begin
            valid_reg  <= valid_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            plan_reg            <= plan_in;
            px_reg[SIDE_TOP]    <= OUT_W'(in_info.x) + OUT_W'(q[SIDE_TOP]);
            py_reg[SIDE_TOP]    <= OUT_W'(in_info.y);
            px_reg[SIDE_LEFT]   <= OUT_W'(in_info.x);
            py_reg[SIDE_LEFT]   <= OUT_W'(in_info.y) + OUT_W'(q[SIDE_LEFT]);
            px_reg[SIDE_RIGHT]  <= OUT_W'(in_info.x) + OUT_W'(in_info.s);
            py_reg[SIDE_RIGHT]  <= OUT_W'(in_info.y) + OUT_W'(q[SIDE_RIGHT]);
            px_reg[SIDE_BOTTOM] <= OUT_W'(in_info.x) + OUT_W'(q[SIDE_BOTTOM]);
            py_reg[SIDE_BOTTOM] <= OUT_W'(in_info.y) + OUT_W'(in_info.s);
        end
    end

    assign s_side = second_reg ? plan_reg.start1 : plan_reg.start0;
    assign e_side = second_reg ? plan_reg.end1   : plan_reg.end0;

    assign m_valid             = valid_reg;
    assign m_data.start_x      = px_reg[s_side];
    assign m_data.start_y      = py_reg[s_side];
    assign m_data.end_x        = px_reg[e_side];
    assign m_data.end_y        = py_reg[e_side];
    assign m_data.last_segment = last;

    `MSQ_ASSERT_IMPL(a_second_saddle, second_reg, valid_reg && plan_reg.count == 2'd2, "second segment shown for a non-saddle cell")
    `MSQ_ASSERT_NEXT(a_second_follows, take && !last, valid_reg && second_reg, "saddle cell lost its second segment")
    `MSQ_ASSERT_IMPL(a_no_empty_cell, valid_reg, plan_reg.count != 2'd0, "cell without segments held for output")

endmodule

[rtl/core/marching_squares_cell_segments_top.sv]
// ----------------------------------------------------------------------------
// marching_squares_cell_segments_top
// One square cell in, its marching-squares segments out, with rounded
// linear interpolation of the edge crossings.
// ----------------------------------------------------------------------------
// A cell item enters in any cycle in which s_ready is high and its first
// segment is offered after two front stages for magnitudes and products,
// one divider stage per quotient bit and one output stage, the first front
// stage loaded at the accepting edge. Cells with one segment stream at one
// per cycle while the result side does not stall; a saddle cell holds the
// single result port for both of its segments; cells with no segment produce
// no item and take no turn at the result port. Stalls on the result side back
// up through the stage valid bits without losing or repeating items.
module marching_squares_cell_segments_top
    import msq_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  msq_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output msq_out_t m_data
);

    cell_info_t                  in_info;
    cell_info_t                  tail_info;
    logic [PIPE_STAGES-1:0]      load;
    logic                        tail_valid;
    logic                        tail_ready;
    lane_t [N_SIDES-1:0]         lanes;
    logic [N_SIDES-1:0][Q_W-1:0] q;

    assign in_info.x   = s_data.cell_x;
    assign in_info.y   = s_data.cell_y;
    assign in_info.s   = s_data.cell_size;
    assign in_info.idx = {~s_data.corner_bottom_right[VALUE_W-1],
                          ~s_data.corner_bottom_left[VALUE_W-1],
                          ~s_data.corner_top_right[VALUE_W-1],
                          ~s_data.corner_top_left[VALUE_W-1]};

    msq_pipe_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_info   (in_info),
        .load      (load),
        .out_valid (tail_valid),
        .out_info  (tail_info),
        .out_ready (tail_ready)
    );

    msq_front u_front (
        .aclk    (aclk),
        .load0   (load[0]),
        .load1   (load[1]),
        .in_data (s_data),
        .lanes   (lanes)
    );

    for (genvar k = 0; k < N_SIDES; k++) begin : g_lane
        msq_div_lane u_div (
            .aclk    (aclk),
            .load    (load[FRONT_STAGES +: DIV_STAGES]),
            .in_lane (lanes[k]),
            .q       (q[k])
        );
    end

    msq_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (tail_valid),
        .in_ready (tail_ready),
        .in_info  (tail_info),
        .q        (q),
        .m_valid  (m_valid),
        .m_data   (m_data),
        .m_ready  (m_ready)
    );

endmodule
